/* sv/assert_macros.svh */
// Assertion macros shared by the replacement policy modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on aclk, off while aresetn is low
`define AST_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, clocked on aclk, off while aresetn is low
`define AST_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* sv/pacr_pkg.sv */
// Types, constants and codes of the phase-adaptive replacement policy
`default_nettype none
package pacr_pkg;

    localparam int NUM_SETS   = 2048;
    localparam int NUM_WAYS   = 16;
    localparam int HIST_DEPTH = 8;

    localparam int SET_W   = $clog2(NUM_SETS);
    localparam int WAY_W   = $clog2(NUM_WAYS);
    localparam int PTR_W   = $clog2(HIST_DEPTH);
    localparam int CNT_W   = $clog2(HIST_DEPTH + 1);
    localparam int CLR_W   = SET_W + 1;
    localparam int ADDR_W  = 64;
    localparam int STAMP_W = 32;
    localparam int SCORE_W = 16;
    localparam int THR_W   = 4;
    localparam int SEED_W  = 16;
    localparam int APB_AW  = 3;

    localparam logic [STAMP_W-1:0] STAMP_MAX     = '1;
    localparam logic [SCORE_W-1:0] SCORE_MAX     = '1;
    localparam logic [SCORE_W:0]   HIT_BONUS     = (SCORE_W+1)'(2);
    localparam logic [SCORE_W-1:0] SPATIAL_SCORE = SCORE_W'(2);
    localparam logic [SEED_W-1:0]  LFSR_TAPS     = 16'hB400;
    localparam logic [THR_W-1:0]   RST_THRESHOLD = 4'd6;
    localparam logic [SEED_W-1:0]  RST_SEED      = 16'd44257;

    // Register indexes, selected by paddr[2]
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_SEED      = 1'b1;

    typedef logic [HIST_DEPTH-1:0][ADDR_W-1:0]  hist_row_t;
    typedef logic [NUM_WAYS-1:0][STAMP_W-1:0]   stamp_row_t;
    typedef logic [NUM_WAYS-1:0][SCORE_W-1:0]   score_row_t;

    typedef enum logic [1:0] {
        MODE_LRU     = 2'd0,
        MODE_REUSE   = 2'd1,
        MODE_SPATIAL = 2'd2
    } mode_t;

    typedef struct packed {
        logic [PTR_W-1:0]   hptr;
        logic [PTR_W-1:0]   sptr;
        logic [1:0]         mode;
        logic [THR_W-1:0]   disagree;
        logic [STAMP_W-1:0] max_stamp;
    } meta_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic eval;
        logic write;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic result_pending;
        logic out_busy;
    } dp_status_t;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic              seed_load;
        logic [SEED_W-1:0] seed;
    } cfg_t;

endpackage
`default_nettype wire

/* sv/pacr_ram.sv */
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module pacr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* sv/pacr_ctrl.sv */
// Controller state machine: clearing pass, accept, read, evaluate, write back
`default_nettype none
`include "assert_macros.svh"
module pacr_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output      logic                s_ready,
    input  wire pacr_pkg::dp_status_t status,
    output      pacr_pkg::ctrl_cmd_t  cmd_o
);
    import pacr_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd_o.clear = 1'b1;
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_o.accept = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                cmd_o.eval = 1'b1;
                // an item that ends a run holds while a finished result still occupies the output
                if (!(status.result_pending && status.out_busy)) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd_o.write = 1'b1;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    `AST_NXT(a_accept_read, cmd_o.accept, state_reg == ST_READ)
    `AST_NXT(a_write_idle, state_reg == ST_WRITE, state_reg == ST_IDLE)
    `AST_IMP(a_clear_blocks, state_reg == ST_CLEAR, !s_ready)

endmodule
`default_nettype wire

/* sv/pacr_datapath.sv */
// Datapath: set memories, phase detection, victim selection, stamps, scores, LFSR
`default_nettype none
`include "assert_macros.svh"
module pacr_datapath (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire pacr_pkg::ctrl_cmd_t            cmd,
    output      pacr_pkg::dp_status_t           status,
    input  wire pacr_pkg::cfg_t                 cfg,
    input  wire logic                           s_func,
    input  wire logic [pacr_pkg::SET_W-1:0]     s_set_index,
    input  wire logic [pacr_pkg::WAY_W-1:0]     s_way_index,
    input  wire logic [pacr_pkg::ADDR_W-1:0]    s_way_block_address,
    input  wire logic [pacr_pkg::ADDR_W-1:0]    s_line_address,
    input  wire logic [pacr_pkg::ADDR_W-1:0]    s_pc_value,
    input  wire logic [pacr_pkg::ADDR_W-1:0]    s_evicted_address,
    input  wire logic                           s_was_hit,
    input  wire logic                           s_run_last,
    output      logic                           m_valid,
    input  wire logic                           m_ready,
    output      logic [pacr_pkg::WAY_W-1:0]     m_victim_way,
    output      logic [1:0]                     m_mode_used,
    output      logic                           m_used_random
);
    import pacr_pkg::*;

    // latched item
    logic              func_reg, hit_reg, last_reg;
    logic [SET_W-1:0]  set_reg;
    logic [WAY_W-1:0]  way_reg;
    logic [ADDR_W-1:0] blk_reg, addr_reg, pc_reg, ev_reg;

    // run state
    logic               run_active_reg, run_found_reg;
    logic [SET_W-1:0]   run_set_reg;
    logic [1:0]         run_mode_reg;
    logic [WAY_W-1:0]   run_cand_reg;
    logic [STAMP_W-1:0] run_best_reg;

    logic [SEED_W-1:0] lfsr_reg;
    logic [CLR_W-1:0]  clr_cnt_reg;

    // evaluation results
    logic [1:0]       det_mode_reg;
    logic [CNT_W-1:0] match_cnt_reg;
    logic             ev_in_reg, blk_absent_reg;

    logic             m_valid_reg;
    logic [WAY_W-1:0] m_way_reg;
    logic [1:0]       m_mode_reg;
    logic             m_rnd_reg;

    // memory ports
    hist_row_t  arow, prow, srow, arow_new, prow_new, srow_new;
    stamp_row_t stamp_row, stamp_new;
    score_row_t score_row, score_new;
    meta_t      meta_rd, meta_new;
    logic [SET_W-1:0] raddr, waddr;
    logic       we_hist, we_meta, we_way;
    logic [SET_W-1:0] clr_addr;

    assign clr_addr = clr_cnt_reg[SET_W-1:0];
    assign raddr    = (s_func || !run_active_reg) ? s_set_index : run_set_reg;
    assign waddr    = cmd.clear ? clr_addr : set_reg;
    assign we_hist  = cmd.clear || (cmd.write && func_reg);
    assign we_way   = we_hist;
    assign we_meta  = cmd.clear || (cmd.write && (func_reg || !run_active_reg));

    pacr_ram #(.WIDTH($bits(hist_row_t)), .DEPTH(NUM_SETS)) u_addr_ram (
        .aclk(aclk), .we(we_hist), .waddr(waddr),
        .wdata(cmd.clear ? hist_row_t'('0) : arow_new),
        .re(cmd.accept), .raddr(raddr), .rdata(arow)
    );
    pacr_ram #(.WIDTH($bits(hist_row_t)), .DEPTH(NUM_SETS)) u_pc_ram (
        .aclk(aclk), .we(we_hist), .waddr(waddr),
        .wdata(cmd.clear ? hist_row_t'('0) : prow_new),
        .re(cmd.accept), .raddr(raddr), .rdata(prow)
    );
    pacr_ram #(.WIDTH($bits(hist_row_t)), .DEPTH(NUM_SETS)) u_stride_ram (
        .aclk(aclk), .we(we_hist), .waddr(waddr),
        .wdata(cmd.clear ? hist_row_t'('0) : srow_new),
        .re(cmd.accept), .raddr(raddr), .rdata(srow)
    );
    pacr_ram #(.WIDTH($bits(meta_t)), .DEPTH(NUM_SETS)) u_meta_ram (
        .aclk(aclk), .we(we_meta), .waddr(waddr),
        .wdata(cmd.clear ? meta_t'('0) : meta_new),
        .re(cmd.accept), .raddr(raddr), .rdata(meta_rd)
    );
    pacr_ram #(.WIDTH($bits(stamp_row_t)), .DEPTH(NUM_SETS)) u_stamp_ram (
        .aclk(aclk), .we(we_way), .waddr(waddr),
        .wdata(cmd.clear ? stamp_row_t'('0) : stamp_new),
        .re(cmd.accept), .raddr(raddr), .rdata(stamp_row)
    );
    pacr_ram #(.WIDTH($bits(score_row_t)), .DEPTH(NUM_SETS)) u_score_ram (
        .aclk(aclk), .we(we_way), .waddr(waddr),
        .wdata(cmd.clear ? score_row_t'('0) : score_new),
        .re(cmd.accept), .raddr(raddr), .rdata(score_row)
    );

    // evaluation: history compares and phase detection
    logic [1:0]       det_mode_next;
    logic [CNT_W-1:0] match_cnt_next;
    logic             ev_in_next, blk_absent_next;

    always_comb begin
        logic [CNT_W-1:0] spatial, distinct;
        logic             dup, blk_hit;
        spatial         = '0;
        distinct        = '0;
        blk_hit         = 1'b0;
        match_cnt_next  = CNT_W'(1);
        ev_in_next      = (ev_reg == addr_reg);
        for (int i = 1; i < HIST_DEPTH; i++) begin
            spatial = spatial + CNT_W'(srow[i] == srow[i-1] && srow[i] != '0);
        end
        for (int i = 0; i < HIST_DEPTH; i++) begin
            dup = 1'b0;
            for (int j = 0; j < i; j++) begin
                dup = dup | (prow[j] == prow[i]);
            end
            distinct = distinct + CNT_W'(!dup);
        end
        for (int i = 0; i < HIST_DEPTH; i++) begin
            blk_hit = blk_hit | (arow[i] == blk_reg);
            // count against the row as it stands after this access is recorded
            if (PTR_W'(i) != meta_rd.hptr) begin
                match_cnt_next = match_cnt_next + CNT_W'(arow[i] == addr_reg);
                ev_in_next     = ev_in_next | (arow[i] == ev_reg);
            end
        end
        blk_absent_next = !blk_hit;
        if (spatial > CNT_W'(HIST_DEPTH / 2)) begin
            det_mode_next = MODE_SPATIAL;
        end else if (distinct > CNT_W'(HIST_DEPTH / 2)) begin
            det_mode_next = MODE_REUSE;
        end else begin
            det_mode_next = MODE_LRU;
        end
    end

    // write-back stage
    logic               first;
    logic [1:0]         mode_eff;
    logic               found_new;
    logic [WAY_W-1:0]   cand_new;
    logic [STAMP_W-1:0] best_new;
    logic [SEED_W-1:0]  lfsr_step;

    assign first     = !run_active_reg;
    assign lfsr_step = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : '0);

    always_comb begin
        logic [PTR_W-1:0]   p, prevp;
        logic [STAMP_W-1:0] stamp_inc, v;
        logic [SCORE_W:0]   sc;
        logic               found_eff;
        logic [WAY_W-1:0]   cand_eff;
        logic [STAMP_W-1:0] best_eff;
        p         = meta_rd.hptr;
        prevp     = p - PTR_W'(1);
        arow_new  = arow;
        prow_new  = prow;
        srow_new  = srow;
        stamp_new = stamp_row;
        score_new = score_row;
        meta_new  = meta_rd;
        arow_new[p] = addr_reg;
        prow_new[p] = pc_reg;
        stamp_inc = (meta_rd.max_stamp == STAMP_MAX) ? STAMP_MAX
                                                     : meta_rd.max_stamp + STAMP_W'(1);
        sc = {1'b0, score_row[way_reg]};
        if (hit_reg) begin
            sc = sc + HIT_BONUS;
        end else if (sc != '0) begin
            sc = sc - (SCORE_W+1)'(1);
        end
        sc = sc + (SCORE_W+1)'(match_cnt_reg);

        if (func_reg) begin
            if (p != '0) begin
                srow_new[meta_rd.sptr] = addr_reg - arow[prevp];
                meta_new.sptr          = meta_rd.sptr + PTR_W'(1);
            end
            meta_new.hptr = p + PTR_W'(1);
            case (meta_rd.mode)
                MODE_LRU: begin
                    stamp_new[way_reg] = stamp_inc;
                    meta_new.max_stamp = stamp_inc;
                end
                MODE_REUSE: begin
                    score_new[way_reg] = sc[SCORE_W] ? SCORE_MAX : sc[SCORE_W-1:0];
                end
                default: begin
                    score_new[way_reg] = ev_in_reg ? SPATIAL_SCORE : '0;
                end
            endcase
        end else if (first) begin
            // phase re-detection on the first item of a run
            if (det_mode_reg != meta_rd.mode) begin
                if (meta_rd.disagree + THR_W'(1) >= cfg.threshold) begin
                    meta_new.mode     = det_mode_reg;
                    meta_new.disagree = '0;
                end else begin
                    meta_new.disagree = meta_rd.disagree + THR_W'(1);
                end
            end else begin
                meta_new.disagree = '0;
            end
        end

        mode_eff  = first ? meta_new.mode : run_mode_reg;
        found_eff = first ? 1'b0 : run_found_reg;
        cand_eff  = first ? '0 : run_cand_reg;
        best_eff  = first ? '0 : run_best_reg;
        found_new = found_eff;
        cand_new  = cand_eff;
        best_new  = best_eff;
        v = (mode_eff == MODE_LRU) ? stamp_row[way_reg]
                                   : {{(STAMP_W-SCORE_W){1'b0}}, score_row[way_reg]};
        if (mode_eff == MODE_SPATIAL) begin
            if (blk_absent_reg && (!found_eff || way_reg < cand_eff)) begin
                found_new = 1'b1;
                cand_new  = way_reg;
            end
        end else if (!found_eff || v < best_eff || (v == best_eff && way_reg < cand_eff)) begin
            found_new = 1'b1;
            cand_new  = way_reg;
            best_new  = v;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg <= s_func;
            set_reg  <= raddr;
            way_reg  <= s_way_index;
            blk_reg  <= s_way_block_address;
            addr_reg <= s_line_address;
            pc_reg   <= s_pc_value;
            ev_reg   <= s_evicted_address;
            hit_reg  <= s_was_hit;
            last_reg <= s_run_last;
        end
        if (cmd.eval) begin
            det_mode_reg   <= det_mode_next;
            match_cnt_reg  <= match_cnt_next;
            ev_in_reg      <= ev_in_next;
            blk_absent_reg <= blk_absent_next;
        end
        if (cmd.write && !func_reg) begin
            run_set_reg  <= set_reg;
            run_mode_reg <= mode_eff;
            run_cand_reg <= last_reg ? '0 : cand_new;
            run_best_reg <= last_reg ? '0 : best_new;
        end
        if (cmd.write && !func_reg && last_reg) begin
            m_way_reg  <= found_new ? cand_new : lfsr_step[WAY_W-1:0];
            m_mode_reg <= mode_eff;
            m_rnd_reg  <= !found_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_active_reg <= 1'b0;
            run_found_reg  <= 1'b0;
            lfsr_reg       <= RST_SEED;
            clr_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            end
            if (cfg.seed_load) begin
                lfsr_reg <= (cfg.seed == '0) ? SEED_W'(1) : cfg.seed;
            end else if (cmd.write && !func_reg && last_reg && !found_new) begin
                lfsr_reg <= lfsr_step;
            end
            if (cmd.write && !func_reg) begin
                run_active_reg <= !last_reg;
                run_found_reg  <= last_reg ? 1'b0 : found_new;
            end
            if (cmd.write && !func_reg && last_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clear_done     = (clr_cnt_reg == CLR_W'(NUM_SETS - 1));
    assign status.result_pending = !func_reg && last_reg;
    assign status.out_busy       = m_valid_reg && !m_ready;

    assign m_valid       = m_valid_reg;
    assign m_victim_way  = m_way_reg;
    assign m_mode_used   = m_mode_reg;
    assign m_used_random = m_rnd_reg;

    `AST_IMP(a_out_free, cmd.write && status.result_pending, !(m_valid_reg && !m_ready))

endmodule
`default_nettype wire

/* sv/phase_adaptive_cache_replacement_top.sv */
// Top level: APB registers, controller and datapath of the replacement policy
//
//  channel   direction  handshake           payload
//  s_*       in         s_valid / s_ready   func, set, way, addresses, pc, hit, last
//  m_*       out        m_valid / m_ready   victim_way, mode_used, used_random
//  apb       in         psel/penable/pwrite switch_threshold (0x0), lfsr_seed (0x4)
//
// Every item passes through accept, set-memory read, history compare and write back.
// After reset a clearing pass zeroes every entry of the set memories; s_ready is low.
// A result waits in an output register; the next item is accepted meanwhile, and only
// an item that ends a run holds in its compare step while that register is still full.
`default_nettype none
module phase_adaptive_cache_replacement_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output      logic                          s_ready,
    input  wire logic                          s_func,
    input  wire logic [pacr_pkg::SET_W-1:0]    s_set_index,
    input  wire logic [pacr_pkg::WAY_W-1:0]    s_way_index,
    input  wire logic [pacr_pkg::ADDR_W-1:0]   s_way_block_address,
    input  wire logic [pacr_pkg::ADDR_W-1:0]   s_line_address,
    input  wire logic [pacr_pkg::ADDR_W-1:0]   s_pc_value,
    input  wire logic [pacr_pkg::ADDR_W-1:0]   s_evicted_address,
    input  wire logic                          s_was_hit,
    input  wire logic                          s_run_last,
    output      logic                          m_valid,
    input  wire logic                          m_ready,
    output      logic [pacr_pkg::WAY_W-1:0]    m_victim_way,
    output      logic [1:0]                    m_mode_used,
    output      logic                          m_used_random,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pacr_pkg::APB_AW-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output      logic [31:0]                   prdata,
    output      logic                          pready
);
    import pacr_pkg::*;

    logic [THR_W-1:0]  thr_reg;
    logic [SEED_W-1:0] seed_reg;
    logic              wr_en;
    cfg_t              cfg;
    ctrl_cmd_t         cmd;
    dp_status_t        status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= RST_THRESHOLD;
            seed_reg <= RST_SEED;
        end else if (wr_en) begin
            case (paddr[2])
                REG_THRESHOLD: thr_reg  <= pwdata[THR_W-1:0];
                REG_SEED:      seed_reg <= pwdata[SEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_THRESHOLD: prdata = {{(32-THR_W){1'b0}}, thr_reg};
            REG_SEED:      prdata = {{(32-SEED_W){1'b0}}, seed_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.threshold = thr_reg;
    assign cfg.seed_load = wr_en && (paddr[2] == REG_SEED);
    assign cfg.seed      = pwdata[SEED_W-1:0];

    pacr_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .status(status), .cmd_o(cmd)
    );

    pacr_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .status(status), .cfg(cfg),
        .s_func(s_func), .s_set_index(s_set_index), .s_way_index(s_way_index),
        .s_way_block_address(s_way_block_address), .s_line_address(s_line_address),
        .s_pc_value(s_pc_value), .s_evicted_address(s_evicted_address),
        .s_was_hit(s_was_hit), .s_run_last(s_run_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_victim_way(m_victim_way),
        .m_mode_used(m_mode_used), .m_used_random(m_used_random)
    );

endmodule
`default_nettype wire
